FILE: rtl/lgs_pkg.sv
package lgs_pkg;

	localparam int CELL_W      = 8;
	localparam int ROW_BYTES_W = 6;
	localparam int ROW_COUNT_W = 10;
	localparam int CFG_DATA_W  = 10;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 1'b1;

	localparam logic [ROW_BYTES_W-1:0] RST_ROW_BYTES = 6'd25;
	localparam logic [ROW_COUNT_W-1:0] RST_ROW_COUNT = 10'd240;
	localparam int MIN_ROW_BYTES = 2;
	localparam int MIN_ROW_COUNT = 3;

	localparam int DEF_MAX_ROW_BYTES = 32;
	localparam int DEF_MAX_ROWS      = 1023;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [CELL_W-1:0] LEFT_CELL  = 8'h80;
	localparam logic [CELL_W-1:0] RIGHT_CELL = 8'h01;

	localparam logic [3:0] LIFE_BIRTH   = 4'd3;
	localparam logic [3:0] LIFE_SURVIVE = 4'd2;

	// results owed for one accepted byte
	typedef struct packed {
		logic [CELL_W-1:0] pend_byte;
		logic              has_pend;
		logic [CELL_W-1:0] main_byte;
		logic              has_main;
		logic              flush;
	} entry_t;

	// next generation of the middle byte of a 3x3 byte window
	function automatic logic [CELL_W-1:0] life_byte(input logic [23:0] top,
			input logic [23:0] mid, input logic [23:0] bot);
		logic [CELL_W-1:0] res;
		logic [3:0] n;
		for (int b = 0; b < CELL_W; b++) begin
			n = 4'(top[9+b]) + 4'(top[8+b]) + 4'(top[7+b])
			  + 4'(mid[9+b]) + 4'(mid[7+b])
			  + 4'(bot[9+b]) + 4'(bot[8+b]) + 4'(bot[7+b]);
			res[b] = (n == LIFE_BIRTH) || (mid[8+b] && (n == LIFE_SURVIVE));
		end
		return res;
	endfunction

endpackage

FILE: rtl/lgs_front.sv
module lgs_front #(
	parameter int MAX_ROW_BYTES = lgs_pkg::DEF_MAX_ROW_BYTES,
	parameter int MAX_ROWS      = lgs_pkg::DEF_MAX_ROWS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic [$clog2(MAX_ROW_BYTES)-1:0]  last_col,
	input  logic [$clog2(MAX_ROWS)-1:0]       last_row,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lgs_pkg::CELL_W-1:0]        in_data,
	input  logic                              q_full,
	output logic                              q_push,
	output lgs_pkg::entry_t                   q_data
);

	localparam int CW = $clog2(MAX_ROW_BYTES);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int BW = lgs_pkg::CELL_W;

	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic               pend_q;
	logic [2:0][23:0]   win_q;

	logic [BW-1:0]      old_mem [MAX_ROW_BYTES];
	logic [BW-1:0]      mid_mem [MAX_ROW_BYTES];
	logic [BW-1:0]      cur_old_q, cur_mid_q, nxt_old_q, nxt_mid_q;

	logic               v_s1;
	logic [2:0][23:0]   pwin_s1, mwin_s1;
	logic               has_pend_s1, pend_zero_s1, has_main_s1, main_zero_s1;
	logic               left_s1, right_s1, flush_s1;

	logic               accept, first_col, end_col, last_row_now;
	logic [BW-1:0]      v;
	logic [2:0][23:0]   b_win, t_win, p_win;
	logic               has_pend, has_main, main_zero, main_left, main_right;
	logic [CW-1:0]      ra;
	logic [BW-1:0]      pend_res, main_res;

	assign in_ready     = !v_s1 || !q_full;
	assign accept       = in_valid && in_ready;
	assign first_col    = (col_q == '0);
	assign end_col      = (col_q == last_col);
	assign last_row_now = (row_q == last_row);

	always_comb begin
		if (row_q == '0 || last_row_now) begin
			v = '0;
		end else begin
			v = in_data;
			if (first_col) v = v & ~lgs_pkg::LEFT_CELL;
			if (end_col) v = v & ~lgs_pkg::RIGHT_CELL;
		end
	end

	// window after shifting in the new column, left columns cleared at a row start
	always_comb begin
		b_win[0] = {(first_col ? 16'h0 : win_q[0][15:0]), cur_old_q};
		b_win[1] = {(first_col ? 16'h0 : win_q[1][15:0]), cur_mid_q};
		b_win[2] = {(first_col ? 16'h0 : win_q[2][15:0]), v};
		// last row: bottom is known dead, right column comes from the stores
		t_win[0] = {b_win[0][15:0], (end_col ? 8'h0 : nxt_old_q)};
		t_win[1] = {b_win[1][15:0], (end_col ? 8'h0 : nxt_mid_q)};
		t_win[2] = '0;
		p_win[0] = {win_q[0][15:0], 8'h0};
		p_win[1] = {win_q[1][15:0], 8'h0};
		p_win[2] = {win_q[2][15:0], 8'h0};
	end

	always_comb begin
		has_pend = first_col && pend_q;
		has_main = last_row_now || (!first_col && row_q != '0);
		if (last_row_now) begin
			main_zero  = 1'b0;
			main_left  = first_col;
			main_right = end_col;
		end else begin
			main_zero  = (row_q == RW'(1));
			main_left  = (col_q == CW'(1));
			main_right = 1'b0;
		end
	end

	// prefetch two columns ahead, wrapping into the next row
	always_comb begin
		if (end_col) ra = CW'(1);
		else if (col_q + CW'(1) == last_col) ra = '0;
		else ra = col_q + CW'(2);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			old_mem[col_q] <= cur_mid_q;
			mid_mem[col_q] <= v;
			nxt_old_q <= (ra == col_q) ? cur_mid_q : old_mem[ra];
			nxt_mid_q <= (ra == col_q) ? v : mid_mem[ra];
			cur_old_q <= nxt_old_q;
			cur_mid_q <= nxt_mid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= 1'b0;
			win_q  <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= 1'b0;
			win_q  <= '0;
		end else if (accept) begin
			win_q <= b_win;
			if (end_col) begin
				col_q <= '0;
				if (last_row_now) begin
					row_q  <= '0;
					pend_q <= 1'b0;
					win_q  <= '0;
				end else begin
					row_q  <= row_q + RW'(1);
					pend_q <= (row_q != '0);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (restart) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= has_pend || has_main;
		end else if (!q_full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pwin_s1      <= p_win;
			mwin_s1      <= last_row_now ? t_win : b_win;
			has_pend_s1  <= has_pend;
			pend_zero_s1 <= (row_q == RW'(2));
			has_main_s1  <= has_main;
			main_zero_s1 <= main_zero;
			left_s1      <= main_left;
			right_s1     <= main_right;
			flush_s1     <= last_row_now && end_col;
		end
	end

	always_comb begin
		pend_res = lgs_pkg::life_byte(pwin_s1[0], pwin_s1[1], pwin_s1[2]);
		main_res = lgs_pkg::life_byte(mwin_s1[0], mwin_s1[1], mwin_s1[2]);
		q_data.pend_byte = pend_zero_s1 ? '0 : (pend_res & ~lgs_pkg::RIGHT_CELL);
		q_data.has_pend  = has_pend_s1;
		if (main_zero_s1) begin
			q_data.main_byte = '0;
		end else begin
			q_data.main_byte = main_res
				& ~(left_s1 ? lgs_pkg::LEFT_CELL : 8'h0)
				& ~(right_s1 ? lgs_pkg::RIGHT_CELL : 8'h0);
		end
		q_data.has_main  = has_main_s1;
		q_data.flush     = flush_s1;
	end

	assign q_push = v_s1 && !q_full;

endmodule

FILE: rtl/lgs_queue.sv
module lgs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lgs_pkg::entry_t push_data,
	input  logic            pop,
	output lgs_pkg::entry_t head,
	output logic            full,
	output logic            empty
);

	localparam int DEPTH = lgs_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	lgs_pkg::entry_t slots [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + NW'(1);
			else if (pop && !push) count_q <= count_q - NW'(1);
		end
	end

endmodule

FILE: rtl/lgs_back.sv
module lgs_back #(
	parameter int MAX_ROW_BYTES = lgs_pkg::DEF_MAX_ROW_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_ROW_BYTES)-1:0] last_col,
	input  lgs_pkg::entry_t                  head,
	input  logic                             empty,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lgs_pkg::CELL_W-1:0]       out_data,
	output logic                             out_last,
	output logic                             out_done
);

	localparam int CW = $clog2(MAX_ROW_BYTES);

	localparam logic [1:0] PH_PEND = 2'd0;
	localparam logic [1:0] PH_MAIN = 2'd1;
	localparam logic [1:0] PH_ZERO = 2'd2;

	logic [1:0]                  ph_q, kind;
	logic [CW-1:0]               cnt_q;
	logic                        valid_q, last_q, done_q;
	logic [lgs_pkg::CELL_W-1:0]  data_q;
	logic [lgs_pkg::CELL_W-1:0]  beat_data;
	logic                        beat_last, beat_done, load;

	always_comb begin
		priority if (ph_q == PH_PEND && head.has_pend) kind = PH_PEND;
		else if (ph_q != PH_ZERO && head.has_main) kind = PH_MAIN;
		else kind = PH_ZERO;
	end

	always_comb begin
		beat_done = 1'b0;
		unique case (kind)
			PH_PEND: begin
				beat_data = head.pend_byte;
				beat_last = !head.has_main && !head.flush;
			end
			PH_MAIN: begin
				beat_data = head.main_byte;
				beat_last = !head.flush;
			end
			default: begin
				// flush of the all-dead bottom row
				beat_data = '0;
				beat_last = (cnt_q == last_col);
				beat_done = beat_last;
			end
		endcase
	end

	assign load = !empty && (!valid_q || out_ready);
	assign pop  = load && beat_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_PEND;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				if (beat_last) begin
					ph_q  <= PH_PEND;
					cnt_q <= '0;
				end else begin
					ph_q <= (kind == PH_PEND) ? PH_MAIN : PH_ZERO;
					if (kind == PH_ZERO) cnt_q <= cnt_q + CW'(1);
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= beat_data;
			last_q <= beat_last;
			done_q <= beat_done;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;
	assign out_done  = done_q;

endmodule

FILE: rtl/life_generation_stencil.sv
// next generation of a bit-packed life grid (birth on 3, survival on 2 or 3)
//
// s_* carries the current generation in raster order, one byte of eight cells
// per beat, bit 7 leftmost. m_* returns the next generation in the same order;
// m_tlast closes the results owed for one input beat, m_tuser flags the final
// byte of a frame. Edge cells are always dead.
// wr_en/wr_index/wr_data set row_bytes (index 0) and row_count (index 1);
// any write restarts the frame, so write only while the block is idle.
// One input byte is taken per cycle unless the queue is full. A result is
// registered in the window stage, then in the queue, then in the output
// register before it shows on m_tvalid. Result bytes trail the input by one
// row plus one byte; the last byte of a frame releases the end of the row above
// plus row_bytes dead bytes, so that beat yields row_bytes+1 output bytes. Line
// stores are read two columns ahead so that each byte needs one store read.
// A four-entry queue sits between evaluation and output: when m_tready is low
// the queue fills and then s_tready drops; nothing is lost.
// Reset clears position, window and queue; line store contents are never
// needed before they are written within a frame.
module life_generation_stencil #(
	parameter int MAX_ROW_BYTES = lgs_pkg::DEF_MAX_ROW_BYTES,
	parameter int MAX_ROWS      = lgs_pkg::DEF_MAX_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [lgs_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0]   wr_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lgs_pkg::CELL_W-1:0]       s_tdata,   // [7:0] cells_in
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lgs_pkg::CELL_W-1:0]       m_tdata,   // [7:0] cells_out
	output logic                             m_tlast,
	output logic                             m_tuser    // [0] frame_done
);

	localparam int CW  = $clog2(MAX_ROW_BYTES);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int RBW = lgs_pkg::ROW_BYTES_W;
	localparam int RCW = lgs_pkg::ROW_COUNT_W;
	localparam int HW  = (RW + 1 > RCW) ? RW + 1 : RCW;

	localparam logic [RBW-1:0] MAX_W = RBW'(MAX_ROW_BYTES);
	localparam logic [RBW-1:0] MIN_W = RBW'(lgs_pkg::MIN_ROW_BYTES);
	localparam logic [HW-1:0]  MAX_H = HW'(MAX_ROWS);
	localparam logic [HW-1:0]  MIN_H = HW'(lgs_pkg::MIN_ROW_COUNT);

	logic [RBW-1:0]  row_bytes_q, w_eff;
	logic [RCW-1:0]  row_count_q;
	logic [HW-1:0]   h_full, h_eff;
	logic [CW-1:0]   last_col;
	logic [RW-1:0]   last_row;

	logic            q_push, q_pop, q_full, q_empty;
	lgs_pkg::entry_t q_in, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= lgs_pkg::RST_ROW_BYTES;
			row_count_q <= lgs_pkg::RST_ROW_COUNT;
		end else if (wr_en) begin
			unique case (wr_index)
				lgs_pkg::CFG_ROW_BYTES: row_bytes_q <= wr_data[RBW-1:0];
				lgs_pkg::CFG_ROW_COUNT: row_count_q <= wr_data[RCW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (row_bytes_q < MIN_W) w_eff = MIN_W;
		else if (row_bytes_q > MAX_W) w_eff = MAX_W;
		else w_eff = row_bytes_q;
		h_full = HW'(row_count_q);
		if (h_full < MIN_H) h_eff = MIN_H;
		else if (h_full > MAX_H) h_eff = MAX_H;
		else h_eff = h_full;
	end

	assign last_col = CW'(w_eff - RBW'(1));
	assign last_row = RW'(h_eff - HW'(1));

	lgs_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.MAX_ROWS     (MAX_ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (wr_en),
		.last_col(last_col),
		.last_row(last_row),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_data (s_tdata),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_in)
	);

	lgs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	lgs_back #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.last_col (last_col),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_last (m_tlast),
		.out_done (m_tuser)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("frame end not on the last beat of its input");

	a_push_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_in.has_pend || q_in.has_main))
		else $error("queue entry without any result");

endmodule

FILE: test/life_generation_stencil_tb.sv
module life_generation_stencil_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [lgs_pkg::CELL_W-1:0] cells;
		logic                       run_last;
		logic                       frame_done;
	} gen_beat_t;

	typedef enum logic {ROW_WRITE, ROW_BEAT} plan_kind_t;

	// typed results: first one in the top byte of cells
	typedef struct packed {
		plan_kind_t                      kind;
		logic [lgs_pkg::CFG_INDEX_W-1:0] index;
		logic [lgs_pkg::CFG_DATA_W-1:0]  data;
		logic                            typed;
		logic [1:0]                      count;
		logic                            frame_end;
		logic [23:0]                     cells;
	} plan_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            wr_en;
	logic [lgs_pkg::CFG_INDEX_W-1:0] wr_index;
	logic [lgs_pkg::CFG_DATA_W-1:0]  wr_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [lgs_pkg::CELL_W-1:0]      s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [lgs_pkg::CELL_W-1:0]      m_tdata;
	logic                            m_tlast;
	logic                            m_tuser;

	// grid state of the predictor
	logic [lgs_pkg::CELL_W-1:0]      two_up [lgs_pkg::DEF_MAX_ROW_BYTES];
	logic [lgs_pkg::CELL_W-1:0]      one_up [lgs_pkg::DEF_MAX_ROW_BYTES];
	logic [23:0]                     win_top, win_mid, win_bot;
	int                              at_col, at_row;
	bit                              owe_row_end;
	logic [lgs_pkg::ROW_BYTES_W-1:0] row_bytes_reg;
	logic [lgs_pkg::ROW_COUNT_W-1:0] row_count_reg;

	gen_beat_t next_gen_due [$];
	gen_beat_t step_results [$];
	int        mismatches;
	int        gap_pct, stall_pct;

	life_generation_stencil DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int grid_w();
		int w;
		w = row_bytes_reg;
		if (w < lgs_pkg::MIN_ROW_BYTES) w = lgs_pkg::MIN_ROW_BYTES;
		if (w > lgs_pkg::DEF_MAX_ROW_BYTES) w = lgs_pkg::DEF_MAX_ROW_BYTES;
		return w;
	endfunction

	function automatic int grid_h();
		int h;
		h = row_count_reg;
		if (h < lgs_pkg::MIN_ROW_COUNT) h = lgs_pkg::MIN_ROW_COUNT;
		if (h > lgs_pkg::DEF_MAX_ROWS) h = lgs_pkg::DEF_MAX_ROWS;
		return h;
	endfunction

	function automatic logic [lgs_pkg::CELL_W-1:0] dead_edges(logic [lgs_pkg::CELL_W-1:0] v,
			int c, int r, int w, int h);
		if (r == 0 || r == h - 1) return '0;
		if (c == 0) v &= ~lgs_pkg::LEFT_CELL;
		if (c == w - 1) v &= ~lgs_pkg::RIGHT_CELL;
		return v;
	endfunction

	// centre byte of three 24-bit rows, left byte in the high bits
	function automatic logic [lgs_pkg::CELL_W-1:0] next_cells(logic [23:0] t, logic [23:0] m,
			logic [23:0] b);
		logic [lgs_pkg::CELL_W-1:0] res;
		int n;
		for (int k = 0; k < lgs_pkg::CELL_W; k++) begin
			n = $countones({t[k+7 +: 3], m[k+9], m[k+7], b[k+7 +: 3]});
			res[k] = (n == lgs_pkg::LIFE_BIRTH) || (m[k+8] && n == lgs_pkg::LIFE_SURVIVE);
		end
		return res;
	endfunction

	function automatic void restart_grid();
		at_col = 0;
		at_row = 0;
		owe_row_end = 1'b0;
		win_top = '0;
		win_mid = '0;
		win_bot = '0;
	endfunction

	function automatic void add_result(logic [lgs_pkg::CELL_W-1:0] cells, logic done);
		step_results.push_back(gen_beat_t'{cells, 1'b0, done});
	endfunction

	function automatic void apply_write(logic [lgs_pkg::CFG_INDEX_W-1:0] idx,
			logic [lgs_pkg::CFG_DATA_W-1:0] data);
		if (idx == lgs_pkg::CFG_ROW_BYTES)
			row_bytes_reg = data[lgs_pkg::ROW_BYTES_W-1:0];
		else
			row_count_reg = data[lgs_pkg::ROW_COUNT_W-1:0];
		restart_grid();
	endfunction

	function automatic void predict_beat(logic [lgs_pkg::CELL_W-1:0] raw);
		int w, h;
		logic [lgs_pkg::CELL_W-1:0] v, tcol, mcol;
		logic [23:0] lt, lm;
		step_results.delete();
		w = grid_w();
		h = grid_h();
		if (at_col >= w || at_row >= h) restart_grid();
		v = dead_edges(raw, at_col, at_row, w, h);
		if (at_col == 0) begin
			// row end of two rows up, its right neighbours are dead
			if (owe_row_end) begin
				add_result(dead_edges(next_cells({win_top[15:0], 8'h00}, {win_mid[15:0], 8'h00},
					{win_bot[15:0], 8'h00}), w - 1, at_row - 2, w, h), 1'b0);
				owe_row_end = 1'b0;
			end
			win_top = '0;
			win_mid = '0;
			win_bot = '0;
		end
		tcol = two_up[at_col];
		mcol = one_up[at_col];
		win_top = {win_top[15:0], tcol};
		win_mid = {win_mid[15:0], mcol};
		win_bot = {win_bot[15:0], v};
		if (at_row == h - 1) begin
			// bottom row known dead: emit row h-2 one byte early
			lt = {win_top[15:0], 8'h00};
			lm = {win_mid[15:0], 8'h00};
			if (at_col + 1 < w) begin
				lt[7:0] = two_up[at_col + 1];
				lm[7:0] = one_up[at_col + 1];
			end
			add_result(dead_edges(next_cells(lt, lm, 24'h0), at_col, h - 2, w, h), 1'b0);
		end else if (at_col >= 1 && at_row >= 1) begin
			add_result(dead_edges(next_cells(win_top, win_mid, win_bot), at_col - 1, at_row - 1,
				w, h), 1'b0);
		end
		two_up[at_col] = mcol;
		one_up[at_col] = v;
		if (at_col + 1 == w) begin
			if (at_row == h - 1) begin
				for (int k = 0; k < w; k++)
					add_result(8'h00, k + 1 == w);
				restart_grid();
			end else begin
				owe_row_end = at_row >= 1;
				at_row++;
				at_col = 0;
			end
		end else begin
			at_col++;
		end
		if (step_results.size() > 0) step_results[$].run_last = 1'b1;
	endfunction

	task automatic cfg_write(input logic [lgs_pkg::CFG_INDEX_W-1:0] idx,
			input logic [lgs_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		apply_write(idx, data);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (next_gen_due.size() != 0);
		// a beat in the first rows owes nothing yet, let it drain
		repeat (16) @(posedge clk);
	endtask

	task automatic send_beat(input logic [lgs_pkg::CELL_W-1:0] cells, input bit from_model);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cells;
		do @(posedge clk); while (!s_tready);
		predict_beat(cells);
		if (from_model)
			foreach (step_results[k]) next_gen_due.push_back(step_results[k]);
	endtask

	always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : result_check
		gen_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (next_gen_due.size() == 0) begin
				$display("%0t: result with none due, got cells=%h last=%b done=%b",
					$time, m_tdata, m_tlast, m_tuser);
				mismatches++;
			end else begin
				want = next_gen_due.pop_front();
				if (want.cells !== m_tdata || want.run_last !== m_tlast
						|| want.frame_done !== m_tuser) begin
					$display("%0t: expected cells=%h last=%b done=%b, got cells=%h last=%b done=%b",
						$time, want.cells, want.run_last, want.frame_done,
						m_tdata, m_tlast, m_tuser);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t plan [21];
		int rand_items, ph, total, style, w, h;
		logic [lgs_pkg::CFG_DATA_W-1:0] rb_data, rc_data;
		logic [lgs_pkg::CELL_W-1:0] cells;

		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		gap_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		foreach (two_up[k]) begin
			two_up[k] = '0;
			one_up[k] = '0;
		end
		row_bytes_reg = lgs_pkg::RST_ROW_BYTES;
		row_count_reg = lgs_pkg::RST_ROW_COUNT;
		restart_grid();

		plan = '{
			// first row of the reset-size grid: nothing due
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0FF, 1'b1, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h000, 1'b1, 2'd0, 1'b0, 24'h000000},
			// both registers below range, upper data bits dropped
			'{ROW_WRITE, lgs_pkg::CFG_ROW_BYTES, 10'h3C0, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_WRITE, lgs_pkg::CFG_ROW_COUNT, 10'h000, 1'b0, 2'd0, 1'b0, 24'h000000},
			// 16x3 all alive: edges die, middle row keeps cells 2..13
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0FF, 1'b1, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0FF, 1'b1, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0FF, 1'b1, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0FF, 1'b1, 2'd1, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0FF, 1'b1, 2'd2, 1'b0, 24'h003F00},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0FF, 1'b1, 2'd3, 1'b1, 24'hFC0000},
			// partial frame, then a write drops the owed row end
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h080, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h001, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h081, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0FF, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_WRITE, lgs_pkg::CFG_ROW_COUNT, 10'h003, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h05A, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0A5, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h03C, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h0C3, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h07E, 1'b0, 2'd0, 1'b0, 24'h000000},
			'{ROW_BEAT,  lgs_pkg::CFG_ROW_BYTES, 10'h081, 1'b0, 2'd0, 1'b0, 24'h000000}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				wait_idle();
				cfg_write(plan[r].index, plan[r].data);
			end else begin
				send_beat(plan[r].data[lgs_pkg::CELL_W-1:0], !plan[r].typed);
				if (plan[r].typed)
					for (int k = 0; k < plan[r].count; k++)
						next_gen_due.push_back(gen_beat_t'{plan[r].cells[23 - 8*k -: 8],
							k == plan[r].count - 1, plan[r].frame_end && k == plan[r].count - 1});
			end
		end

		rand_items = 0;
		ph = 0;
		while (rand_items < 260) begin
			wait_idle();
			unique case (ph % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 64;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 64;
				end
				default: begin
					gap_pct = 37;
					stall_pct = 37;
				end
			endcase

			unique case (ph)
				0: begin
					rb_data = 10'h3FF;
					rc_data = 10'd3;
				end
				1: begin
					rb_data = 10'd2;
					rc_data = 10'h3FF;
				end
				2: begin
					rb_data = 10'd1;
					rc_data = 10'd2;
				end
				default: begin
					rb_data = {4'($urandom), 6'($urandom_range(0, 6))};
					if ($urandom_range(7) == 0) rb_data[lgs_pkg::ROW_BYTES_W-1:0] = 6'($urandom);
					rc_data = 10'($urandom_range(0, 7));
					if ($urandom_range(7) == 0) rc_data = 10'($urandom);
				end
			endcase

			if (ph < 3 || $urandom_range(3) != 0) begin
				if ($urandom_range(1)) begin
					cfg_write(lgs_pkg::CFG_ROW_BYTES, rb_data);
					cfg_write(lgs_pkg::CFG_ROW_COUNT, rc_data);
				end else begin
					cfg_write(lgs_pkg::CFG_ROW_COUNT, rc_data);
					cfg_write(lgs_pkg::CFG_ROW_BYTES, rb_data);
				end
			end else if ($urandom_range(1)) begin
				cfg_write(lgs_pkg::CFG_ROW_BYTES, rb_data);
			end else begin
				cfg_write(lgs_pkg::CFG_ROW_COUNT, rc_data);
			end

			w = grid_w();
			h = grid_h();
			if (ph == 1) begin
				// tallest grid: only its first rows
				total = 4 * w + $urandom_range(0, w - 1);
			end else begin
				total = w * h * ((ph == 0) ? 1 : $urandom_range(1, 2));
				if (total > 128)
					total = $urandom_range(20, 128);
				else if (ph > 2 && $urandom_range(4) == 0)
					total = $urandom_range(1, w * h - 1);
			end
			if (total > 260 - rand_items) total = 260 - rand_items;

			style = $urandom_range(3);
			for (int k = 0; k < total; k++) begin
				if (ph % 3 == 1 && k == total / 2) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (next_gen_due.size() != 0);
				end
				unique case (style)
					0: cells = 8'($urandom);
					1: cells = 8'($urandom & $urandom);
					2: cells = 8'($urandom | $urandom);
					default: cells = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom & $urandom);
				endcase
				send_beat(cells, 1'b1);
				rand_items++;
			end
			ph++;
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (next_gen_due.size() != 0);
		repeat (32) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
